### src/ufcd_pkg.sv
// ----------------------------------------------------------------------------
// ufcd_pkg
// Shared types and constants for the union-find cycle detector: request and
// result structs, status codes, sequencer states and store geometry.
// ----------------------------------------------------------------------------
package ufcd_pkg;

	// Store geometry.
	localparam int MAX_VERTICES = 1024;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int VID_W        = 10;
	localparam int VCOUNT_W     = 11;
	localparam int RANK_W       = 4;
	localparam int RANK_MAX     = 15;
	localparam int VCOUNT_RESET = 1024;

	// Request kinds.
	localparam logic REQ_CLEAR = 1'b0;
	localparam logic REQ_EDGE  = 1'b1;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_MERGED  = 3'd0,
		ST_CYCLE   = 3'd1,
		ST_SKIP    = 3'd2,
		ST_RANGE   = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_FIND,
		S_COMP,
		S_JOIN,
		S_RANK_A,
		S_RANK_B,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             req_type;
		logic [VID_W-1:0] vertex_a;
		logic [VID_W-1:0] vertex_b;
	} in_item_t;

	typedef struct packed {
		status_t status;
		logic    cycle_seen;
	} out_item_t;

endpackage

### src/ufcd_ram.sv
// ----------------------------------------------------------------------------
// ufcd_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ufcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; a same-cycle write to the same entry returns old data.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### src/union_find_cycle_detector.sv
// ----------------------------------------------------------------------------
// union_find_cycle_detector
// Disjoint-set forest over a stream of undirected edges. Each edge finds both
// roots with full path compression, reports a cycle on equal roots and merges
// the two trees by rank otherwise.
//
//  Channel   Signals                           Carries
//  in        in_valid / in_ready / in_data     one request (clear or edge)
//  out       out_valid / out_ready / out_data  status and sticky cycle flag
//  cfg       cfg_wr_en / cfg_wr_data           vertex count register
//
// An edge walks from each endpoint up to its root and then along the same path
// again to compress it, the first endpoint before the second; each step is one
// access of the parent store's read port. A merge then reads both roots' ranks
// and writes the new parent; an edge that closes a cycle skips both. Skipped or
// out-of-range edges go straight to the result.
// A clear request sweeps all MAX_VERTICES entries, one per cycle.
// After reset the same sweep runs once with in_ready low.
// One result may wait in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module union_find_cycle_detector
	import ufcd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data,
	input  logic                cfg_wr_en,
	input  logic [VCOUNT_W-1:0] cfg_wr_data
);

	localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(MAX_VERTICES - 1);

	// Control state.
	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   clr_cnt_q;
	logic                init_q;
	logic                side_q;
	logic                flag_q;
	logic                out_valid_q;
	logic [VCOUNT_W-1:0] vcount_q;

	// Work registers.
	logic [ADDR_W-1:0]   r_q;
	logic [ADDR_W-1:0]   x_q;
	logic [ADDR_W-1:0]   b_q;
	logic [ADDR_W-1:0]   ra_q;
	logic [RANK_W-1:0]   rka_q;
	status_t             res_q;
	out_item_t           out_q;

	// Store ports.
	logic                p_wr_en, k_wr_en;
	logic [ADDR_W-1:0]   p_wr_addr, k_wr_addr, p_rd_addr, k_rd_addr;
	logic [ADDR_W-1:0]   p_wr_data, p_rd;
	logic [RANK_W-1:0]   k_wr_data, k_rd;

	// Decisions.
	logic                accept, out_load, clr_last;
	logic                a_bad, b_bad, range_bad, skip;
	logic                find_hit, comp_done, same_root, rank_lt, rank_gt;

	ufcd_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_VERTICES)) u_parent (
		.clk     (clk),
		.wr_en   (p_wr_en),
		.wr_addr (p_wr_addr),
		.wr_data (p_wr_data),
		.rd_addr (p_rd_addr),
		.rd_data (p_rd)
	);

	ufcd_ram #(.WIDTH(RANK_W), .DEPTH(MAX_VERTICES)) u_rank (
		.clk     (clk),
		.wr_en   (k_wr_en),
		.wr_addr (k_wr_addr),
		.wr_data (k_wr_data),
		.rd_addr (k_rd_addr),
		.rd_data (k_rd)
	);

	// Request classification and walk compares.
	always_comb begin
		a_bad     = (VCOUNT_W'(in_data.vertex_a) >= vcount_q) ||
		            (32'(in_data.vertex_a) >= MAX_VERTICES);
		b_bad     = (VCOUNT_W'(in_data.vertex_b) >= vcount_q) ||
		            (32'(in_data.vertex_b) >= MAX_VERTICES);
		range_bad = a_bad || b_bad;
		skip      = in_data.vertex_a >= in_data.vertex_b;
		find_hit  = p_rd == r_q;
		comp_done = x_q == r_q;
		same_root = ra_q == r_q;
		rank_lt   = rka_q < k_rd;
		rank_gt   = rka_q > k_rd;
		clr_last  = clr_cnt_q == LAST_ENTRY;
		accept    = in_valid && in_ready;
		out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_last) begin
					state_d = init_q ? S_IDLE : S_DONE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					if (in_data.req_type == REQ_CLEAR) begin
						state_d = S_CLEAR;
					end else if (range_bad || skip) begin
						state_d = S_DONE;
					end else begin
						state_d = S_FIND;
					end
				end
			end
			S_FIND: begin
				if (find_hit) begin
					state_d = S_COMP;
				end
			end
			S_COMP: begin
				if (comp_done) begin
					state_d = side_q ? S_JOIN : S_FIND;
				end
			end
			S_JOIN: begin
				state_d = same_root ? S_DONE : S_RANK_A;
			end
			S_RANK_A: begin
				state_d = S_RANK_B;
			end
			S_RANK_B: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Store accesses and handshake outputs.
	always_comb begin
		in_ready  = 1'b0;
		p_wr_en   = 1'b0;
		p_wr_addr = x_q;
		p_wr_data = r_q;
		p_rd_addr = p_rd;
		k_wr_en   = 1'b0;
		k_wr_addr = r_q;
		k_wr_data = RANK_W'(k_rd + 1'b1);
		k_rd_addr = ra_q;
		case (state_q)
			S_CLEAR: begin
				p_wr_en   = 1'b1;
				p_wr_addr = clr_cnt_q;
				p_wr_data = clr_cnt_q;
				k_wr_en   = 1'b1;
				k_wr_addr = clr_cnt_q;
				k_wr_data = '0;
			end
			S_IDLE: begin
				in_ready  = 1'b1;
				p_rd_addr = ADDR_W'(in_data.vertex_a);
			end
			S_FIND: begin
				// On the root, restart at the walk's first vertex to compress.
				p_rd_addr = find_hit ? x_q : p_rd;
			end
			S_COMP: begin
				// Point the visited vertex at the root and step to its old parent.
				p_wr_en   = !comp_done;
				p_rd_addr = comp_done ? b_q : p_rd;
			end
			S_JOIN: begin
				k_rd_addr = ra_q;
			end
			S_RANK_A: begin
				k_rd_addr = r_q;
			end
			S_RANK_B: begin
				// Lower rank goes under higher; a tie puts the first root under the second.
				p_wr_en = 1'b1;
				if (rank_gt) begin
					p_wr_addr = r_q;
					p_wr_data = ra_q;
				end else begin
					p_wr_addr = ra_q;
					p_wr_data = r_q;
				end
				k_wr_en = !rank_lt && !rank_gt && (k_rd != RANK_W'(RANK_MAX));
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			init_q      <= 1'b1;
			side_q      <= 1'b0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
			vcount_q    <= VCOUNT_W'(VCOUNT_RESET);
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				vcount_q <= cfg_wr_data;
			end
			if (state_q == S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_last) begin
					init_q <= 1'b0;
				end
			end
			if (accept) begin
				side_q <= 1'b0;
				if (in_data.req_type == REQ_CLEAR) begin
					clr_cnt_q <= '0;
					flag_q    <= 1'b0;
				end
			end
			if (state_q == S_COMP && comp_done) begin
				side_q <= 1'b1;
			end
			if (state_q == S_JOIN && same_root) begin
				flag_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk registers and result.
	always_ff @(posedge clk) begin
		if (accept) begin
			r_q <= ADDR_W'(in_data.vertex_a);
			x_q <= ADDR_W'(in_data.vertex_a);
			b_q <= ADDR_W'(in_data.vertex_b);
			if (in_data.req_type == REQ_CLEAR) begin
				res_q <= ST_CLEARED;
			end else if (range_bad) begin
				res_q <= ST_RANGE;
			end else if (skip) begin
				res_q <= ST_SKIP;
			end else begin
				res_q <= ST_MERGED;
			end
		end
		if (state_q == S_FIND && !find_hit) begin
			r_q <= p_rd;
		end
		if (state_q == S_COMP) begin
			if (!comp_done) begin
				x_q <= p_rd;
			end else if (!side_q) begin
				ra_q <= r_q;
				r_q  <= b_q;
				x_q  <= b_q;
			end
		end
		if (state_q == S_JOIN && same_root) begin
			res_q <= ST_CYCLE;
		end
		if (state_q == S_RANK_A) begin
			rka_q <= k_rd;
		end
		if (out_load) begin
			out_q.status     <= res_q;
			out_q.cycle_seen <= flag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### src/ufcd_checker.sv
// ----------------------------------------------------------------------------
// ufcd_checker
// Port-level checks for the union-find cycle detector, bound to the top level.
// ----------------------------------------------------------------------------
module ufcd_port_checker
	import ufcd_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// One request at a time: the block is busy right after taking one.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// A clear result always shows the cycle flag cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_CLEARED |-> !out_data.cycle_seen)
		else $error("cycle flag set after clear");

	// An edge that closes a cycle raises the sticky flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_CYCLE |-> out_data.cycle_seen)
		else $error("cycle reported without flag");

endmodule

bind union_find_cycle_detector ufcd_port_checker u_ufcd_checker (.*);

### sim/ufcd_checker.sv
// ----------------------------------------------------------------------------
// ufcd_checker
// Watches the request, result and register ports of the union-find cycle
// detector. It keeps its own disjoint-set forest, works out the answer to
// every accepted request and checks each result against the oldest one.
// ----------------------------------------------------------------------------
module ufcd_checker
	import ufcd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  in_item_t            in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  out_item_t           out_data,
	input  logic                cfg_wr_en,
	input  logic [VCOUNT_W-1:0] cfg_wr_data,
	output int                  mismatches,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow of the forest, the sticky flag and the vertex count.
	logic [VID_W-1:0]    link_mem [MAX_VERTICES];
	logic [RANK_W-1:0]   rank_mem [MAX_VERTICES];
	logic                loop_seen;
	logic [VCOUNT_W-1:0] vcount_shadow;

	// Answers owed by the block, oldest first.
	out_item_t answer_q [$];
	out_item_t want;
	int        error_total = 0;

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		error_total++;
	endtask

	function automatic void reset_forest();
		for (int i = 0; i < MAX_VERTICES; i++) begin
			link_mem[i] = VID_W'(i);
			rank_mem[i] = '0;
		end
		loop_seen = 1'b0;
	endfunction

	// Walk up to the root, then point every vertex on the path straight at it.
	function automatic logic [VID_W-1:0] find_root(input logic [VID_W-1:0] v);
		logic [VID_W-1:0] r;
		logic [VID_W-1:0] x;
		logic [VID_W-1:0] nxt;
		int               steps;
		r = v;
		steps = 0;
		while (link_mem[r] != r && steps < MAX_VERTICES) begin
			r = link_mem[r];
			steps++;
		end
		x = v;
		steps = 0;
		while (x != r && steps < MAX_VERTICES) begin
			nxt = link_mem[x];
			link_mem[x] = r;
			x = nxt;
			steps++;
		end
		return r;
	endfunction

	// Apply one request to the shadow forest and return the result it owes.
	function automatic out_item_t apply_request(input in_item_t rq);
		out_item_t        res;
		logic [VID_W-1:0] ra;
		logic [VID_W-1:0] rb;
		if (rq.req_type == REQ_CLEAR) begin
			reset_forest();
			res.status = ST_CLEARED;
		end else if ({1'b0, rq.vertex_a} >= vcount_shadow ||
				{1'b0, rq.vertex_b} >= vcount_shadow) begin
			res.status = ST_RANGE;
		end else if (rq.vertex_a >= rq.vertex_b) begin
			res.status = ST_SKIP;
		end else begin
			ra = find_root(rq.vertex_a);
			rb = find_root(rq.vertex_b);
			if (ra == rb) begin
				loop_seen = 1'b1;
				res.status = ST_CYCLE;
			end else begin
				// Union by rank; a tie puts the first root under the second.
				if (rank_mem[ra] < rank_mem[rb]) begin
					link_mem[ra] = rb;
				end else if (rank_mem[ra] > rank_mem[rb]) begin
					link_mem[rb] = ra;
				end else begin
					link_mem[ra] = rb;
					if (rank_mem[rb] < RANK_W'(RANK_MAX))
						rank_mem[rb] = rank_mem[rb] + 1'b1;
				end
				res.status = ST_MERGED;
			end
		end
		res.cycle_seen = loop_seen;
		return res;
	endfunction

	// Results are checked before the request of the same edge is taken in.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_forest();
			vcount_shadow = VCOUNT_W'(VCOUNT_RESET);
			answer_q.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (answer_q.size() == 0) begin
					report_mismatch("result arrived with no request outstanding");
				end else begin
					want = answer_q.pop_front();
					if (out_data.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							out_data.status, want.status));
					if (out_data.cycle_seen !== want.cycle_seen)
						report_mismatch($sformatf("cycle_seen %0b, expected %0b",
							out_data.cycle_seen, want.cycle_seen));
				end
			end
			if (cfg_wr_en)
				vcount_shadow = cfg_wr_data;
			if (in_valid && in_ready)
				answer_q.push_back(apply_request(in_data));
			outstanding <= answer_q.size();
			mismatches  <= error_total;
		end
	end

endmodule

### sim/union_find_cycle_detector_tb.sv
// ----------------------------------------------------------------------------
// union_find_cycle_detector_tb
// Drives the cycle detector with directed edges, clears and register writes,
// then with random phases at several vertex counts, most under random idling on
// both channels. The checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module union_find_cycle_detector_tb
	import ufcd_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS_PER_PHASE = 165;
	localparam int LONG_HOLD       = 300;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	in_item_t            in_data;
	logic                out_valid;
	logic                out_ready;
	out_item_t           out_data;
	logic                cfg_wr_en;
	logic [VCOUNT_W-1:0] cfg_wr_data;
	int                  mismatches;
	int                  outstanding;

	// Shared pacing controls, changed only by the stimulus process.
	logic burst_mode;
	int   hold_ticket;

	int vc_plan [8] = '{16, 1024, 40, 3, 300, 1, 100, 8};

	union_find_cycle_detector i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	ufcd_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// Clock with a 4 ns period.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog for a hung run.
	initial begin
		#4ms;
		$display("Simulation FAILED");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off when asked.
	initial begin
		int gap;
		int holds_served;
		holds_served = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = burst_mode ? 0 : $urandom_range(0, 4);
			if (hold_ticket != holds_served) begin
				gap = LONG_HOLD;
				holds_served = hold_ticket;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	function automatic in_item_t edge_req(input int a, input int b);
		in_item_t it;
		it.req_type = REQ_EDGE;
		it.vertex_a = VID_W'(a);
		it.vertex_b = VID_W'(b);
		return it;
	endfunction

	function automatic in_item_t clear_req();
		in_item_t it;
		it = '0;
		it.req_type = REQ_CLEAR;
		it.vertex_a = VID_W'($urandom);
		it.vertex_b = VID_W'($urandom);
		return it;
	endfunction

	// Mostly well-formed edges inside a small window, so that trees grow
	// deep and cycles close; the rest are clears and unconstrained noise.
	function automatic in_item_t random_req(input int vc);
		int roll;
		int span;
		int base;
		int a;
		int b;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			return clear_req();
		if (roll < 85 && vc >= 2) begin
			span = (vc > 48) ? 48 : vc;
			base = ($urandom_range(0, 3) * (vc - span)) / 3;
			a = base + $urandom_range(0, span - 2);
			b = $urandom_range(a + 1, base + span - 1);
			return edge_req(a, b);
		end
		return edge_req($urandom_range(0, 1023), $urandom_range(0, 1023));
	endfunction

	// Offer one request after a random gap and hold it until it is taken.
	task automatic send_req(input in_item_t item);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data  <= item;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stop offering and wait until every owed result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_vcount(input int value);
		drain();
		cfg_wr_data <= VCOUNT_W'(value);
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		@(posedge clk);
	endtask

	// Reset, directed part, random phases, verdict.
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		burst_mode  = 1'b0;
		hold_ticket = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset vertex count: extreme ids, skips, a cycle and a clear.
		send_req(edge_req(0, 1023));
		send_req(edge_req(1023, 0));
		send_req(edge_req(5, 5));
		send_req(edge_req(0, 1023));
		send_req(clear_req());
		send_req(edge_req(3, 900));
		send_req(edge_req(4, 900));

		// Lowered count keeps the forest; the shared root lies above it.
		write_vcount(8);
		send_req(edge_req(3, 4));
		send_req(edge_req(3, 8));
		send_req(edge_req(8, 3));
		send_req(edge_req(7, 7));

		// Smallest count: only vertex zero is in range.
		write_vcount(1);
		send_req(edge_req(0, 0));
		send_req(edge_req(0, 1));
		send_req(edge_req(1023, 1023));

		write_vcount(2);
		send_req(clear_req());
		send_req(edge_req(0, 1));
		send_req(edge_req(0, 1));
		send_req(edge_req(1, 0));

		write_vcount(1023);
		send_req(edge_req(0, 1022));
		send_req(edge_req(0, 1023));
		send_req(edge_req(1022, 1023));

		// Random phases at several counts, with and without idling.
		for (int p = 0; p < 8; p++) begin
			write_vcount(vc_plan[p]);
			burst_mode <= (p == 2 || p == 5);
			if (p == 4)
				hold_ticket <= hold_ticket + 1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_req(random_req(vc_plan[p]));
		end
		write_vcount(1024);
		for (int n = 0; n < 40; n++)
			send_req(random_req(1024));

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
